/* rtl/lars_pkg.sv */
`timescale 1ns / 1ps

package lars_pkg;

    localparam int MAX_WIDTH = 64;
    localparam int CFG_W     = 7;
    localparam int MIN_WIDTH = 3;
    localparam int Q_DEPTH   = 4;
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
    localparam int ROWS_W    = 2;

    localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] WIDTH_MIN   = CFG_W'(MIN_WIDTH);
    localparam logic [CFG_W-1:0] WIDTH_MAX   = CFG_W'(MAX_WIDTH);

    localparam logic [ROWS_W-1:0] ROWS_NONE = 2'd0;
    localparam logic [ROWS_W-1:0] ROWS_ONE  = 2'd1;
    localparam logic [ROWS_W-1:0] ROWS_FULL = 2'd2;

    typedef logic [MAX_WIDTH-1:0] t_row;

    typedef struct packed {
        t_row row;
        logic frame_end;
    } t_result;

endpackage

/* rtl/life_automaton_row_step_top.sv */
`timescale 1ns / 1ps

// Results are registered into an output queue when the row causing them is accepted.
// Throughput: one row per cycle; a frame's last row yields up to two results, drained
// one per cycle unless i_stall, from a four-entry queue that stalls input when nearly full.
// Reset (synchronous, active low): frame state and queue cleared, active width 64.
// Configuration is always ready and takes effect on the next row.
module life_automaton_row_step_top
    import lars_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [63:0]      i_row_cells,
    input  logic             i_last_row,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [63:0]      o_next_row,
    output logic             o_frame_end,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_active_width
);

    logic [CFG_W-1:0]   r_width;
    t_row               r_prior;
    t_row               r_older;
    logic [ROWS_W-1:0]  r_rows;
    t_result            r_q [Q_DEPTH];
    logic [Q_CNT_W-1:0] r_count;

    logic [CFG_W-1:0]   n_width;
    t_row               n_prior;
    t_row               n_older;
    logic [ROWS_W-1:0]  n_rows;
    t_result            n_q [Q_DEPTH];
    logic [Q_CNT_W-1:0] n_count;

    logic               accept;
    logic               pop;
    t_row               mask;
    t_row               cur;
    t_row               above;
    t_row               mid;
    t_row               gen;
    logic [3:0]         cnt;
    logic               has_mid;
    logic               push0;
    logic               push1;
    t_result            res0;
    t_result            res1;
    t_result            res_mid;
    t_result            res_last;
    logic [Q_CNT_W-1:0] base;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_count > Q_CNT_W'(Q_DEPTH - 2));
    assign accept      = i_valid && !o_stall;
    assign o_valid     = (r_count != '0);
    assign pop         = o_valid && !i_stall;
    assign o_next_row  = r_q[0].row;
    assign o_frame_end = r_q[0].frame_end;

    // clamp on write so the stored width is always in range
    always_comb begin
        n_width = r_width;
        if (i_cfg_valid) begin
            if (i_cfg_active_width < WIDTH_MIN) begin
                n_width = WIDTH_MIN;
            end else if (i_cfg_active_width > WIDTH_MAX) begin
                n_width = WIDTH_MAX;
            end else begin
                n_width = i_cfg_active_width;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_WIDTH; k++) begin
            mask[k] = (CFG_W'(k) < r_width);
        end
    end

    assign cur   = i_row_cells & mask;
    assign above = r_older & mask;
    assign mid   = r_prior & mask;

    always_comb begin
        gen = '0;
        cnt = '0;
        for (int k = 1; k < MAX_WIDTH - 1; k++) begin
            cnt = 4'(above[k-1]) + 4'(above[k]) + 4'(above[k+1])
                + 4'(mid[k-1]) + 4'(mid[k+1])
                + 4'(cur[k-1]) + 4'(cur[k]) + 4'(cur[k+1]);
            if (CFG_W'(k + 1) < r_width) begin
                gen[k] = (cnt == 4'd3) || (mid[k] && cnt == 4'd2);
            end
        end
        // first and last active columns pass through
        for (int k = 0; k < MAX_WIDTH; k++) begin
            if (k == 0 || CFG_W'(k) == r_width - CFG_W'(1)) begin
                gen[k] = mid[k];
            end
        end
        gen = gen & mask;
    end

    always_comb begin
        has_mid            = (r_rows != ROWS_NONE);
        res_mid.row        = (r_rows == ROWS_ONE) ? mid : gen;
        res_mid.frame_end  = 1'b0;
        res_last.row       = cur;
        res_last.frame_end = 1'b1;
        res0               = has_mid ? res_mid : res_last;
        res1               = res_last;
        push0              = accept && (has_mid || i_last_row);
        push1              = accept && has_mid && i_last_row;
    end

    always_comb begin
        n_prior = r_prior;
        n_older = r_older;
        n_rows  = r_rows;
        if (accept) begin
            if (i_last_row) begin
                n_prior = '0;
                n_older = '0;
                n_rows  = ROWS_NONE;
            end else begin
                n_older = r_prior;
                n_prior = cur;
                if (r_rows != ROWS_FULL) begin
                    n_rows = r_rows + ROWS_W'(1);
                end
            end
        end
    end

    // shift queue: head at entry 0, appends land at the first free entry
    always_comb begin
        base    = r_count - Q_CNT_W'(pop);
        n_count = base + Q_CNT_W'(push0) + Q_CNT_W'(push1);
        for (int i = 0; i < Q_DEPTH; i++) begin
            if (pop && i < Q_DEPTH - 1) begin
                n_q[i] = r_q[i+1];
            end else begin
                n_q[i] = r_q[i];
            end
            if (push0 && base == Q_CNT_W'(i)) begin
                n_q[i] = res0;
            end
            if (push1 && base + Q_CNT_W'(1) == Q_CNT_W'(i)) begin
                n_q[i] = res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
            r_prior <= '0;
            r_older <= '0;
            r_rows  <= ROWS_NONE;
            r_count <= '0;
        end else begin
            r_width <= n_width;
            r_prior <= n_prior;
            r_older <= n_older;
            r_rows  <= n_rows;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < Q_DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

endmodule

/* verif/tb_life_automaton_row_step_top.sv */
`timescale 1ns / 1ps

module tb_life_automaton_row_step_top;
    import lars_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE      = 8;
    localparam t_row BLINKER   = 64'h0000_0000_0000_1C00;

    typedef enum int {MIX_EVEN, MIX_SPARSE, MIX_THIN, MIX_DENSE} t_density;

    class life_scoreboard;
        logic [CFG_W-1:0]  width_cfg;
        t_row              row_above;
        t_row              row_mid;
        logic [ROWS_W-1:0] rows_held;
        t_result           rows_due[$];
        int                errors;

        function new();
            width_cfg = WIDTH_RESET;
            row_above = '0;
            row_mid   = '0;
            rows_held = ROWS_NONE;
            errors    = 0;
        endfunction

        function void set_width(logic [CFG_W-1:0] w);
            width_cfg = w;
        endfunction

        function int cells_in_use();
            if (width_cfg < WIDTH_MIN) return MIN_WIDTH;
            if (width_cfg > WIDTH_MAX) return MAX_WIDTH;
            return int'(width_cfg);
        endfunction

        function t_row cell_mask(int w);
            t_row m;
            m = '1;
            if (w < MAX_WIDTH) m = (t_row'(1) << w) - t_row'(1);
            return m;
        endfunction

        function t_row next_generation(t_row above, t_row mid, t_row below, int w);
            t_row res;
            int   cnt;
            res      = '0;
            res[0]   = mid[0];
            res[w-1] = mid[w-1];
            for (int k = 1; k < w - 1; k++) begin
                cnt = int'(above[k-1]) + int'(above[k]) + int'(above[k+1])
                    + int'(mid[k-1]) + int'(mid[k+1])
                    + int'(below[k-1]) + int'(below[k]) + int'(below[k+1]);
                res[k] = mid[k] ? (cnt == 2 || cnt == 3) : (cnt == 3);
            end
            return res;
        endfunction

        function void queue_row(t_row cells, logic frame_end);
            t_result r;
            r.row       = cells;
            r.frame_end = frame_end;
            rows_due.push_back(r);
        endfunction

        // one accepted input transaction
        function void note_row(t_row cells, logic last);
            int   w;
            t_row m;
            t_row cur;
            w   = cells_in_use();
            m   = cell_mask(w);
            cur = cells & m;
            if (rows_held == ROWS_ONE)
                queue_row(row_mid & m, 1'b0);
            else if (rows_held == ROWS_FULL)
                queue_row(next_generation(row_above & m, row_mid & m, cur, w), 1'b0);
            if (last) begin
                queue_row(cur, 1'b1);
                row_above = '0;
                row_mid   = '0;
                rows_held = ROWS_NONE;
            end else begin
                row_above = row_mid;
                row_mid   = cur;
                if (rows_held != ROWS_FULL) rows_held = rows_held + 1'b1;
            end
        endfunction

        // one accepted output transaction
        function void check_row(t_row cells, logic frame_end);
            t_result want;
            if (rows_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected row: expected none, actual %h frame_end %b",
                         $time, cells, frame_end);
                return;
            end
            want = rows_due.pop_front();
            if (cells !== want.row) begin
                errors++;
                $display("%0t: next_row mismatch: expected %h, actual %h",
                         $time, want.row, cells);
            end
            if (frame_end !== want.frame_end) begin
                errors++;
                $display("%0t: frame_end mismatch: expected %b, actual %b",
                         $time, want.frame_end, frame_end);
            end
        endfunction

        function int pending();
            return rows_due.size();
        endfunction
    endclass

    logic             i_clk              = 1'b0;
    logic             i_rst_n            = 1'b0;
    logic             i_valid            = 1'b0;
    logic [63:0]      i_row_cells        = '0;
    logic             i_last_row         = 1'b0;
    logic             i_stall            = 1'b0;
    logic             i_cfg_valid        = 1'b0;
    logic [CFG_W-1:0] i_cfg_active_width = '0;
    logic             o_stall;
    logic             o_valid;
    logic [63:0]      o_next_row;
    logic             o_frame_end;
    logic             o_cfg_ready;

    life_scoreboard sb;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    int       hold_reqs      = 0;
    int       hold_served    = 0;
    int       hold_left      = 0;
    int       quiet_cycles   = 0;
    int       frame_left     = 0;
    t_density frame_mix      = MIX_EVEN;

    life_automaton_row_step_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_row_cells        (i_row_cells),
        .i_last_row         (i_last_row),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_next_row         (o_next_row),
        .o_frame_end        (o_frame_end),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_active_width (i_cfg_active_width)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) sb.note_row(i_row_cells, i_last_row);
        if (i_rst_n && i_cfg_valid && o_cfg_ready) sb.set_width(i_cfg_active_width);
    end

    // receiver: check results, random stall, long hold on request
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_row(o_next_row, o_frame_end);
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else if (hold_served != hold_reqs) begin
            hold_served = hold_served + 1;
            hold_left   = HOLD_CYCLES;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("life_automaton_row_step_top verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_row(t_row cells, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_row_cells <= cells;
        i_last_row  <= last;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reconfigure(logic [CFG_W-1:0] w);
        drain();
        i_cfg_valid        <= 1'b1;
        i_cfg_active_width <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_row random_row(t_density mix);
        t_row a;
        t_row b;
        t_row c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case (mix)
            MIX_SPARSE: return a & b;
            MIX_THIN:   return a & b & c;
            MIX_DENSE:  return a | b;
            default:    return a;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_width();
        int r;
        r = $urandom_range(99);
        if (r < 15) return CFG_W'($urandom_range(0, 2));
        if (r < 30) return WIDTH_MIN;
        if (r < 45) return WIDTH_MAX;
        if (r < 55) return CFG_W'($urandom_range(65, 127));
        return CFG_W'($urandom_range(4, 63));
    endfunction

    // frames run on across calls, so a width change can land mid-frame
    task automatic run_rows(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            if (frame_left == 0) begin
                pick = $urandom_range(99);
                if (pick < 8)       frame_left = 1;
                else if (pick < 16) frame_left = 2;
                else                frame_left = $urandom_range(3, 14);
                frame_mix = t_density'($urandom_range(0, 3));
            end
            frame_left = frame_left - 1;
            send_row(random_row(frame_mix), frame_left == 0);
        end
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-row and two-row frames
        send_row('1, 1'b1);
        send_row('1, 1'b0);
        send_row('0, 1'b1);
        // full grid: interior dies of crowding
        send_row('1, 1'b0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        // blinker
        send_row('0, 1'b0);
        send_row('0, 1'b0);
        send_row(BLINKER, 1'b0);
        send_row('0, 1'b0);
        send_row('0, 1'b1);
        // width change with rows held
        send_row('1, 1'b0);
        send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        reconfigure(CFG_W'(5));
        send_row('1, 1'b0);
        send_row(64'h15, 1'b1);
        // width below minimum, at minimum, above maximum
        reconfigure('0);
        send_row('1, 1'b0);
        send_row(64'h2, 1'b0);
        send_row('1, 1'b1);
        reconfigure(WIDTH_MIN);
        send_row(64'h7, 1'b0);
        send_row(64'h5, 1'b0);
        send_row(64'hFFFF_FFFF_FFFF_FFF2, 1'b1);
        reconfigure(CFG_W'(127));
        send_row(64'h8000_0000_0000_0001, 1'b0);
        send_row('1, 1'b0);
        send_row(64'h0123_4567_89AB_CDEF, 1'b1);

        // fill the output queue against a long receiver hold
        reconfigure(WIDTH_MAX);
        hold_reqs = hold_reqs + 1;
        run_rows(30);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            for (int chunk = 0; chunk < 4; chunk++) begin
                reconfigure(pick_width());
                run_rows(52);
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("life_automaton_row_step_top verification clean");
        else
            $display("life_automaton_row_step_top verification failed");
        $finish;
    end

endmodule
